// ----- rtl/i2p_pkg.sv -----
package i2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int RES_DEPTH   = 4;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_OPEN = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_POW  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    K_SPACE   = 3'd0,
    K_OPERAND = 3'd1,
    K_OPEN    = 3'd2,
    K_CLOSE   = 3'd3,
    K_OPER    = 3'd4
  } kind_t;

  // Classified input word handed from the front end to the stack engine.
  typedef struct packed {
    kind_t      kind;
    op_t        code;
    logic [7:0] chr;
    logic       last;
  } cls_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_present;
    logic       syntax_error;
    logic       end_of_output;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] depth;
    logic [CNT_W-1:0] opens;
  } eng_stat_t;

  function automatic op_t char_code(logic [7:0] ch);
    op_t c;
    unique case (ch)
      CH_OPEN: c = OP_OPEN;
      CH_ADD:  c = OP_ADD;
      CH_SUB:  c = OP_SUB;
      CH_MUL:  c = OP_MUL;
      CH_DIV:  c = OP_DIV;
      CH_POW:  c = OP_POW;
      default: c = OP_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] code_char(op_t c);
    logic [7:0] ch;
    unique case (c)
      OP_OPEN: ch = CH_OPEN;
      OP_ADD:  ch = CH_ADD;
      OP_SUB:  ch = CH_SUB;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      OP_POW:  ch = CH_POW;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] code_prio(op_t c);
    logic [2:0] p;
    unique case (c)
      OP_OPEN:        p = 3'd1;
      OP_ADD, OP_SUB: p = 3'd2;
      OP_MUL, OP_DIV: p = 3'd3;
      OP_POW:         p = 3'd4;
      default:        p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/i2p_front.sv -----
module i2p_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    in_char,
  input  logic          is_final,
  output logic          full,
  output logic          cls_valid,
  output i2p_pkg::cls_t cls,
  input  logic          cls_ready
);
  import i2p_pkg::*;

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  cls_t            word_in;
  op_t             code;
  cls_t            q [QUEUE_DEPTH];
  logic [QP_W-1:0] head;
  logic [QP_W-1:0] tail;
  logic [QC_W-1:0] cnt;
  logic            wr;
  logic            rd;

  always_comb begin
    code = char_code(in_char);
    word_in.code = code;
    word_in.chr  = in_char;
    word_in.last = is_final;
    if (in_char == CH_SPACE) begin
      word_in.kind = K_SPACE;
    end else if (in_char == CH_CLOSE) begin
      word_in.kind = K_CLOSE;
    end else if (code == OP_OPEN) begin
      word_in.kind = K_OPEN;
    end else if (code != OP_NONE) begin
      word_in.kind = K_OPER;
    end else begin
      word_in.kind = K_OPERAND;
    end
  end

  assign full      = (cnt == QC_W'(QUEUE_DEPTH));
  assign cls_valid = (cnt != '0);
  assign cls       = q[head];
  assign wr        = push && !full;
  assign rd        = cls_valid && cls_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (wr) begin
        tail <= (tail == QP_W'(QUEUE_DEPTH - 1)) ? '0 : tail + QP_W'(1);
      end
      if (rd) begin
        head <= (head == QP_W'(QUEUE_DEPTH - 1)) ? '0 : head + QP_W'(1);
      end
      if (wr && !rd) begin
        cnt <= cnt + QC_W'(1);
      end else if (rd && !wr) begin
        cnt <= cnt - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[tail] <= word_in;
    end
  end

endmodule

// ----- rtl/i2p_back.sv -----
module i2p_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cls_valid,
  input  i2p_pkg::cls_t      cls,
  output logic               cls_ready,
  output logic               res_push,
  output i2p_pkg::res_t      res,
  input  logic               res_full,
  output i2p_pkg::eng_stat_t stat
);
  import i2p_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_CLOSE = 5'b00100,
    S_FLUSH = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state, state_next;
  op_t              stack [STACK_DEPTH];
  logic [CNT_W-1:0] depth, depth_next;
  logic [CNT_W-1:0] opens, opens_next;
  logic [CNT_W-1:0] depth_m1;
  logic             error_seen, error_seen_next;
  logic             step_err, step_err_next;
  op_t              cur_code, cur_code_next;
  logic [2:0]       cur_prio, cur_prio_next;
  logic             cur_last, cur_last_next;
  logic             hold_valid;
  logic [7:0]       hold_char;
  logic             hold_present;

  op_t              top;
  logic             stk_empty;
  logic             stk_full;
  logic             go;
  logic             wr_en;
  logic             emit;
  logic [7:0]       emit_char;
  logic             emit_present;
  logic             finish;
  logic             new_err;
  state_t           after_item;

  assign depth_m1  = depth - CNT_W'(1);
  assign top       = stack[depth_m1[SP_W-1:0]];
  assign stk_empty = (depth == '0);
  assign stk_full  = (depth == CNT_W'(STACK_DEPTH));
  assign go        = !res_full;
  assign cls_ready = (state == S_IDLE) && go;

  always_comb begin
    state_next      = state;
    depth_next      = depth;
    opens_next      = opens;
    error_seen_next = error_seen;
    step_err_next   = step_err;
    cur_code_next   = cur_code;
    cur_prio_next   = cur_prio;
    cur_last_next   = cur_last;
    wr_en           = 1'b0;
    emit            = 1'b0;
    emit_char       = code_char(top);
    emit_present    = 1'b1;
    finish          = 1'b0;
    new_err         = 1'b0;
    after_item      = cur_last ? S_FLUSH : S_DONE;

    unique case (state)
      S_IDLE: begin
        if (cls_valid && go) begin
          cur_code_next = cls.code;
          cur_prio_next = code_prio(cls.code);
          cur_last_next = cls.last;
          after_item    = cls.last ? S_FLUSH : S_DONE;
          // The error of the whole step is known up front: an operator
          // overflows only if the full stack would not pop at all, and a
          // closing parenthesis is unmatched if no '(' is stacked.
          case (cls.kind)
            K_OPEN:  new_err = stk_full;
            K_CLOSE: new_err = (opens == '0);
            K_OPER:  new_err = stk_full && (code_prio(top) < code_prio(cls.code));
            default: new_err = 1'b0;
          endcase
          step_err_next   = error_seen | new_err;
          error_seen_next = error_seen | new_err;
          case (cls.kind)
            K_OPERAND: begin
              emit       = 1'b1;
              emit_char  = cls.chr;
              state_next = after_item;
            end
            K_OPEN: begin
              if (!stk_full) begin
                wr_en      = 1'b1;
                depth_next = depth + CNT_W'(1);
                opens_next = opens + CNT_W'(1);
              end
              state_next = after_item;
            end
            K_CLOSE: state_next = S_CLOSE;
            K_OPER:  state_next = S_POP;
            default: state_next = after_item;
          endcase
        end
      end
      S_POP: begin
        if (go) begin
          if (!stk_empty && (cur_prio <= code_prio(top))) begin
            emit       = 1'b1;
            depth_next = depth_m1;
          end else begin
            if (!stk_full) begin
              wr_en      = 1'b1;
              depth_next = depth + CNT_W'(1);
            end
            state_next = after_item;
          end
        end
      end
      S_CLOSE: begin
        if (go) begin
          if (stk_empty) begin
            state_next = after_item;
          end else begin
            depth_next = depth_m1;
            if (top == OP_OPEN) begin
              opens_next = opens - CNT_W'(1);
              state_next = after_item;
            end else begin
              emit = 1'b1;
            end
          end
        end
      end
      S_FLUSH: begin
        if (go) begin
          emit = 1'b1;
          if (!stk_empty) begin
            depth_next = depth_m1;
            if (top == OP_OPEN) begin
              opens_next = opens - CNT_W'(1);
            end
          end else begin
            emit_char    = 8'h00;
            emit_present = 1'b0;
            state_next   = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (go) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          if (cur_last) begin
            error_seen_next = 1'b0;
            opens_next      = '0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // One result is held back so that the last one of a step can be marked
  // when the step closes.
  assign res_push           = hold_valid && (emit || finish);
  assign res.out_char       = hold_char;
  assign res.char_present   = hold_present;
  assign res.syntax_error   = step_err;
  assign res.end_of_output  = finish;

  assign stat.depth = depth;
  assign stat.opens = opens;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      depth      <= '0;
      opens      <= '0;
      error_seen <= 1'b0;
      step_err   <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state      <= state_next;
      depth      <= depth_next;
      opens      <= opens_next;
      error_seen <= error_seen_next;
      step_err   <= step_err_next;
      if (emit) begin
        hold_valid <= 1'b1;
      end else if (finish) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_code <= cur_code_next;
    cur_prio <= cur_prio_next;
    cur_last <= cur_last_next;
    if (emit) begin
      hold_char    <= emit_char;
      hold_present <= emit_present;
    end
    if (wr_en) begin
      stack[depth[SP_W-1:0]] <= cur_code_next;
    end
  end

endmodule

// ----- rtl/i2p_res_fifo.sv -----
module i2p_res_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  i2p_pkg::res_t wdata,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output i2p_pkg::res_t rdata
);
  import i2p_pkg::*;

  localparam int RP_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int RC_W = $clog2(RES_DEPTH + 1);

  res_t            mem [RES_DEPTH];
  logic [RP_W-1:0] head;
  logic [RP_W-1:0] tail;
  logic [RC_W-1:0] cnt;
  logic            do_wr;
  logic            do_rd;

  assign full  = (cnt == RC_W'(RES_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[head];
  assign do_wr = wr && !full;
  assign do_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        tail <= (tail == RP_W'(RES_DEPTH - 1)) ? '0 : tail + RP_W'(1);
      end
      if (do_rd) begin
        head <= (head == RP_W'(RES_DEPTH - 1)) ? '0 : head + RP_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + RC_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - RC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[tail] <= wdata;
    end
  end

endmodule

// ----- rtl/infix_to_postfix_converter.sv -----
// Shunting-yard converter: infix characters go in one word at a time and the
// postfix characters come out, with a terminator word after the last
// character of an expression. A front end classifies each character into a
// two-word queue; the stack engine behind it handles one character at a time
// and writes into a four-word result queue. For each character the engine
// handles it, pops entries from its 16-entry stack as needed, and then closes
// its run of results; an operator also pushes itself, and a closing
// parenthesis drops its '(' or finds the stack empty. For the final
// character the engine also pops every entry left on the stack and writes the
// terminator before it closes the run. Each operator is pushed and popped at
// most once. The engine takes a new character only after closing the run of
// the last one, and it stalls while the result queue is full.
module infix_to_postfix_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_char,
  input  logic       is_final,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       char_present,
  output logic       syntax_error,
  output logic       end_of_output
);
  import i2p_pkg::*;

  logic      cls_valid;
  cls_t      cls;
  logic      cls_ready;
  logic      res_push;
  res_t      res_in;
  res_t      res_out;
  logic      res_full;
  eng_stat_t stat;

  i2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_char   (in_char),
    .is_final  (is_final),
    .full      (full),
    .cls_valid (cls_valid),
    .cls       (cls),
    .cls_ready (cls_ready)
  );

  i2p_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (cls_valid),
    .cls       (cls),
    .cls_ready (cls_ready),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full),
    .stat      (stat)
  );

  i2p_res_fifo u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_in),
    .full  (res_full),
    .empty (empty),
    .pop   (pop),
    .rdata (res_out)
  );

  assign out_char      = res_out.out_char;
  assign char_present  = res_out.char_present;
  assign syntax_error  = res_out.syntax_error;
  assign end_of_output = res_out.end_of_output;

  // Every stacked '(' is counted, so the count can never exceed the depth.
  a_opens_le_depth: assert property (@(posedge clk) disable iff (rst)
    stat.opens <= stat.depth)
    else $error("open parenthesis count exceeds stack depth");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    stat.depth <= CNT_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // The terminator word always closes its run.
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !char_present) |-> end_of_output)
    else $error("terminator word not marked as last");

  // The engine never writes a result while the result queue is full.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_full |-> !res_push)
    else $error("result written into a full queue");

endmodule
